>>> design/rsas_pkg.sv
// rsas_pkg: shared constants, op codes, fsm states and the
// command / status structs between rsas_ctrl and rsas_dp
// no dependencies
`default_nettype none

package rsas_pkg;

  localparam int unsigned CAP   = 1024;
  localparam int unsigned IDX_W = $clog2(CAP);
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 10;
  localparam int unsigned OP_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_LAST
  } state_e;

  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic rd_probe;
    logic rd_last;
    logic step_left;
    logic step_right;
    logic res_hit;
    logic res_miss;
  } dp_cmd_t;

  typedef struct packed {
    logic range_empty;
    logic hit;
    logic left_sorted;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/rsas_dp.sv
// rsas_dp: element memory, element count, search bounds and result register
// depends on rsas_pkg; driven by commands from rsas_ctrl
`default_nettype none

module rsas_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rsas_pkg::dp_cmd_t                 cmd_i,
  output rsas_pkg::dp_sts_t                 sts_o,
  input  logic signed [rsas_pkg::VAL_W-1:0] value_i,
  output logic                              found_o,
  output logic [rsas_pkg::POS_W-1:0]        position_o
);

  logic [rsas_pkg::VAL_W-1:0] mem [rsas_pkg::CAP];

  logic [rsas_pkg::CNT_W-1:0] count_q, count_d;
  logic [rsas_pkg::CNT_W-1:0] first_q, first_d;
  logic [rsas_pkg::CNT_W-1:0] last_q, last_d;
  logic signed [rsas_pkg::VAL_W-1:0] target_q;
  logic signed [rsas_pkg::VAL_W-1:0] ra_q;
  logic signed [rsas_pkg::VAL_W-1:0] rb_q;
  logic found_q;
  logic [rsas_pkg::POS_W-1:0] pos_q;

  logic [rsas_pkg::CNT_W:0]   sum;
  logic [rsas_pkg::CNT_W-1:0] mid_full;
  logic [rsas_pkg::CNT_W-1:0] mid_inc;
  logic [rsas_pkg::CNT_W-1:0] last_dec;
  logic [rsas_pkg::IDX_W-1:0] mid_idx;
  logic [rsas_pkg::IDX_W-1:0] addr_b;
  logic                       not_full;

  assign sum      = {1'b0, first_q} + {1'b0, last_q};
  assign mid_full = sum[rsas_pkg::CNT_W:1];
  assign mid_idx  = mid_full[rsas_pkg::IDX_W-1:0];
  assign mid_inc  = mid_full + rsas_pkg::CNT_W'(1);
  assign last_dec = last_q - rsas_pkg::CNT_W'(1);
  assign addr_b   = cmd_i.rd_last ? last_dec[rsas_pkg::IDX_W-1:0]
                                  : first_q[rsas_pkg::IDX_W-1:0];
  assign not_full = (count_q != rsas_pkg::CNT_W'(rsas_pkg::CAP));

  // memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && not_full) begin
      mem[count_q[rsas_pkg::IDX_W-1:0]] <= value_i;
    end
    if (cmd_i.rd_probe) begin
      ra_q <= mem[mid_idx];
    end
    if (cmd_i.rd_probe || cmd_i.rd_last) begin
      rb_q <= mem[addr_b];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.append && not_full) begin
      count_d = count_q + rsas_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    first_d = first_q;
    last_d  = last_q;
    if (cmd_i.start) begin
      first_d = '0;
      last_d  = count_q;
    end else if (cmd_i.step_left) begin
      if ((rb_q <= target_q) && (target_q < ra_q)) begin
        last_d = mid_full;
      end else begin
        first_d = mid_inc;
      end
    end else if (cmd_i.step_right) begin
      if ((ra_q < target_q) && (target_q <= rb_q)) begin
        first_d = mid_inc;
      end else begin
        last_d = mid_full;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else begin
      count_q <= count_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      target_q <= value_i;
    end
    if (cmd_i.res_hit || cmd_i.res_miss) begin
      found_q <= cmd_i.res_hit;
      pos_q   <= cmd_i.res_hit ? rsas_pkg::POS_W'(mid_idx) : '0;
    end
  end

  assign sts_o.range_empty = (first_q == last_q);
  assign sts_o.hit         = (ra_q == target_q);
  assign sts_o.left_sorted = (rb_q <= ra_q);

  assign found_o    = found_q;
  assign position_o = pos_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rsas_pkg::CNT_W'(rsas_pkg::CAP))
    else $error("element count above capacity");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q <= last_q)
    else $error("search bounds crossed");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_hit || cmd_i.res_miss) |=> (found_q == $past(cmd_i.res_hit)))
    else $error("result flag not loaded");

endmodule

`default_nettype wire

>>> design/rsas_ctrl.sv
// rsas_ctrl: request handshake, search state machine and result valid flag
// depends on rsas_pkg; commands rsas_dp
`default_nettype none

module rsas_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rsas_pkg::OP_W-1:0]        op_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rsas_pkg::dp_cmd_t                cmd_o,
  input  rsas_pkg::dp_sts_t                sts_i
);

  rsas_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;
  rsas_pkg::op_e op;

  assign op       = rsas_pkg::op_e'(op_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rsas_pkg::ST_IDLE: begin
        if (accept && op == rsas_pkg::OP_SEARCH) begin
          state_d = rsas_pkg::ST_PROBE;
        end
      end
      rsas_pkg::ST_PROBE: begin
        if (!sts_i.range_empty) begin
          state_d = rsas_pkg::ST_CMP;
        end else if (out_free) begin
          state_d = rsas_pkg::ST_IDLE;
        end
      end
      rsas_pkg::ST_CMP: begin
        if (sts_i.hit) begin
          if (out_free) begin
            state_d = rsas_pkg::ST_IDLE;
          end
        end else if (sts_i.left_sorted) begin
          state_d = rsas_pkg::ST_PROBE;
        end else begin
          state_d = rsas_pkg::ST_LAST;
        end
      end
      rsas_pkg::ST_LAST: begin
        state_d = rsas_pkg::ST_PROBE;
      end
      default: begin
        state_d = rsas_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      rsas_pkg::ST_IDLE: begin
        cmd_o.clear  = accept && op == rsas_pkg::OP_CLEAR;
        cmd_o.append = accept && op == rsas_pkg::OP_APPEND;
        cmd_o.start  = accept && op == rsas_pkg::OP_SEARCH;
      end
      rsas_pkg::ST_PROBE: begin
        cmd_o.rd_probe = !sts_i.range_empty;
        cmd_o.res_miss = sts_i.range_empty && out_free;
      end
      rsas_pkg::ST_CMP: begin
        cmd_o.res_hit   = sts_i.hit && out_free;
        cmd_o.step_left = !sts_i.hit && sts_i.left_sorted;
        cmd_o.rd_last   = !sts_i.hit && !sts_i.left_sorted;
      end
      rsas_pkg::ST_LAST: begin
        cmd_o.step_right = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.res_hit || cmd_o.res_miss || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsas_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != rsas_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.res_hit || cmd_o.res_miss) |-> !(out_valid_q && out_stall_i))
    else $error("result written over a pending one");

  a_search_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == rsas_pkg::ST_PROBE)
    else $error("search request did not start a probe");

  a_last_read_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_last |-> (!sts_i.hit && !sts_i.left_sorted))
    else $error("last element read without a right-sorted probe");

endmodule

`default_nettype wire

>>> design/rotated_sorted_array_search_top.sv
// clear and append requests are carried out from ST_IDLE; a search loads its bounds and then
// runs probes through ST_PROBE and ST_CMP (and ST_LAST when the right half is checked through
// the memory read of the last element), at most 11 probes over 1024 elements
// one request at a time; the result register frees the input side once a result is loaded
// rst_ni (async, active low) empties the array and drops any pending result
// top level: rsas_ctrl and rsas_dp, depends on rsas_pkg
`default_nettype none

module rotated_sorted_array_search_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rsas_pkg::OP_W-1:0]         in_op_i,
  input  logic signed [rsas_pkg::VAL_W-1:0] in_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              out_found_o,
  output logic [rsas_pkg::POS_W-1:0]        out_position_o
);

  rsas_pkg::dp_cmd_t cmd;
  rsas_pkg::dp_sts_t sts;

  rsas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (in_op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rsas_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .value_i    (in_value_i),
    .found_o    (out_found_o),
    .position_o (out_position_o)
  );

endmodule

`default_nettype wire
